// File: design/bed_pkg.sv
`default_nettype none
package bed_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;
  localparam int unsigned ModeW = 2;

  // Item kinds
  localparam logic [KindW-1:0] KIND_BYTE = 2'd0;
  localparam logic [KindW-1:0] KIND_EOA  = 2'd1;
  localparam logic [KindW-1:0] KIND_EOS  = 2'd2;

  // Decode modes
  localparam logic [ModeW-1:0] MODE_PLAIN  = 2'd0;
  localparam logic [ModeW-1:0] MODE_BSLASH = 2'd1;
  localparam logic [ModeW-1:0] MODE_HEX    = 2'd2;
  localparam logic [ModeW-1:0] MODE_OCT    = 2'd3;

  // Register indexes
  localparam logic REG_INTERPRET = 1'b0;
  localparam logic REG_NEWLINE   = 1'b1;

  localparam logic [ByteW-1:0] CH_BSLASH = 8'h5C;
  localparam logic [ByteW-1:0] CH_SPACE  = 8'h20;
  localparam logic [ByteW-1:0] CH_NL     = 8'h0A;
  localparam logic [ByteW-1:0] CH_BEL    = 8'h07;
  localparam logic [ByteW-1:0] CH_BS     = 8'h08;
  localparam logic [ByteW-1:0] CH_ESC    = 8'h1B;
  localparam logic [ByteW-1:0] CH_FF     = 8'h0C;
  localparam logic [ByteW-1:0] CH_CR     = 8'h0D;
  localparam logic [ByteW-1:0] CH_TAB    = 8'h09;
  localparam logic [ByteW-1:0] CH_VT     = 8'h0B;
  localparam logic [ByteW-1:0] CH_ZERO   = 8'h30;
  localparam logic [ByteW-1:0] CH_SEVEN  = 8'h37;
  localparam logic [ByteW-1:0] CH_NINE   = 8'h39;
  localparam logic [ByteW-1:0] CH_LA     = 8'h61;
  localparam logic [ByteW-1:0] CH_LB     = 8'h62;
  localparam logic [ByteW-1:0] CH_LE     = 8'h65;
  localparam logic [ByteW-1:0] CH_LF     = 8'h66;
  localparam logic [ByteW-1:0] CH_LN     = 8'h6E;
  localparam logic [ByteW-1:0] CH_LR     = 8'h72;
  localparam logic [ByteW-1:0] CH_LT     = 8'h74;
  localparam logic [ByteW-1:0] CH_LV     = 8'h76;
  localparam logic [ByteW-1:0] CH_LX     = 8'h78;
  localparam logic [ByteW-1:0] CH_UA     = 8'h41;
  localparam logic [ByteW-1:0] CH_UF     = 8'h46;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } result_t;

endpackage
`default_nettype wire

// File: design/backslash_escape_decoder.sv
`default_nettype none
// Escape decoder for argument byte streams. One input transaction is taken per
// clock unless the input stalls; it is held in an input register, decoded once
// the queue has room, and its zero, one or two output bytes are written into a
// four-entry result queue that drives the output. The output side delivers
// one byte per cycle while out_stall_i is low, so an item that yields two bytes
// (an open escape flushed ahead of the byte or newline that closes it) leaves as
// two separate queue entries; the input stalls only when fewer than two queue
// entries are free. Configuration writes are always ready.
module backslash_escape_decoder
  import bed_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [KindW-1:0] kind_i,
  input  wire logic [ByteW-1:0] in_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [ByteW-1:0] out_byte_o,
  output logic                  last_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic             cfg_index_i,
  input  wire logic             cfg_data_i
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  logic interp_q, newline_q;

  logic             inv_q;
  logic [KindW-1:0] kind_q;
  logic [ByteW-1:0] byte_q;

  logic [ModeW-1:0] mode_q, mode_d;
  logic [ByteW-1:0] val_q, val_d;

  result_t         queue_q [QDepth];
  logic [PtrW-1:0] head_q, tail_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic proc, pop, in_acc;

  logic             a_v, b_v;
  logic [ByteW-1:0] a_b, b_b;
  logic [3:0]       hex_d;
  logic             hex_ok;
  logic [1:0]       n_res;
  logic [ByteW-1:0] r0, r1;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_q  <= 1'b0;
      newline_q <= 1'b1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_INTERPRET) interp_q <= cfg_data_i;
      if (cfg_index_i == REG_NEWLINE) newline_q <= cfg_data_i;
    end
  end

  // Decode needs room for two results
  assign proc       = inv_q && (cnt_q <= CntW'(QDepth - 2));
  assign in_stall_o = inv_q && !proc;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 1'b0;
    end else if (in_acc) begin
      inv_q <= 1'b1;
    end else if (proc) begin
      inv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_i;
      byte_q <= in_byte_i;
    end
  end

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (byte_q >= CH_ZERO && byte_q <= CH_NINE) begin
      hex_d = 4'(byte_q - CH_ZERO);
    end else if (byte_q >= CH_LA && byte_q <= CH_LF) begin
      hex_d = 4'(byte_q - CH_LA + 8'd10);
    end else if (byte_q >= CH_UA && byte_q <= CH_UF) begin
      hex_d = 4'(byte_q - CH_UA + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // Slot a carries a flushed escape, slot b the byte or mark that follows it
  always_comb begin
    a_v    = 1'b0;
    a_b    = val_q;
    b_v    = 1'b0;
    b_b    = byte_q;
    mode_d = mode_q;
    val_d  = val_q;
    if (kind_q == KIND_BYTE || kind_q == KIND_EOA || kind_q == KIND_EOS) begin
      if (!interp_q) begin
        mode_d = MODE_PLAIN;
        val_d  = '0;
        if (kind_q == KIND_BYTE) begin
          b_v = 1'b1;
        end else if (kind_q == KIND_EOA) begin
          b_v = 1'b1;
          b_b = CH_SPACE;
        end else begin
          b_v = newline_q;
          b_b = CH_NL;
        end
      end else if (kind_q == KIND_BYTE) begin
        unique case (mode_q)
          MODE_BSLASH: begin
            mode_d = MODE_PLAIN;
            b_v    = 1'b1;
            case (byte_q)
              CH_LA: b_b = CH_BEL;
              CH_LB: b_b = CH_BS;
              CH_LE: b_b = CH_ESC;
              CH_LF: b_b = CH_FF;
              CH_LN: b_b = CH_NL;
              CH_LR: b_b = CH_CR;
              CH_LT: b_b = CH_TAB;
              CH_LV: b_b = CH_VT;
              CH_LX: begin
                b_v    = 1'b0;
                mode_d = MODE_HEX;
                val_d  = '0;
              end
              CH_ZERO: begin
                b_v    = 1'b0;
                mode_d = MODE_OCT;
                val_d  = '0;
              end
              default: b_b = byte_q;
            endcase
          end
          MODE_HEX, MODE_OCT: begin
            if (mode_q == MODE_HEX && hex_ok) begin
              val_d = {val_q[3:0], hex_d};
            end else if (mode_q == MODE_OCT && byte_q >= CH_ZERO && byte_q <= CH_SEVEN) begin
              val_d = {val_q[4:0], byte_q[2:0]};
            end else begin
              // Close the escape, then take the byte fresh
              a_v   = 1'b1;
              val_d = '0;
              if (byte_q == CH_BSLASH) begin
                mode_d = MODE_BSLASH;
              end else begin
                mode_d = MODE_PLAIN;
                b_v    = 1'b1;
              end
            end
          end
          default: begin
            if (byte_q == CH_BSLASH) begin
              mode_d = MODE_BSLASH;
            end else begin
              b_v = 1'b1;
            end
          end
        endcase
      end else begin
        a_v    = (mode_q != MODE_PLAIN);
        a_b    = (mode_q == MODE_BSLASH) ? CH_BSLASH : val_q;
        mode_d = MODE_PLAIN;
        val_d  = '0;
        b_v    = (kind_q == KIND_EOS) && newline_q;
        b_b    = CH_NL;
      end
    end
  end

  assign n_res = {1'b0, a_v} + {1'b0, b_v};
  assign r0    = a_v ? a_b : b_b;
  assign r1    = b_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      val_q  <= '0;
    end else if (proc) begin
      mode_q <= mode_d;
      val_q  <= val_d;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (proc) cnt_d = cnt_d + CntW'(n_res);
    if (pop) cnt_d = cnt_d - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (pop) head_q <= head_q + PtrW'(1);
      if (proc) tail_q <= tail_q + PtrW'(n_res);
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && n_res != 2'd0) begin
      queue_q[tail_q] <= '{data: r0, last: (n_res == 2'd1)};
    end
    if (proc && n_res == 2'd2) begin
      queue_q[tail_q + PtrW'(1)] <= '{data: r1, last: 1'b1};
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_byte_o  = queue_q[head_q].data;
  assign last_o      = queue_q[head_q].last;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QDepth))
    else $error("result queue overflow");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && !pop |=> cnt_q == $past(cnt_q) + CntW'($past(n_res)))
    else $error("queue count does not follow decoded results");

  a_plain_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && !interp_q && (kind_q == KIND_BYTE || kind_q == KIND_EOA || kind_q == KIND_EOS)
    |=> mode_q == MODE_PLAIN && val_q == '0)
    else $error("escape state left over with decoding off");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> inv_q && cnt_q > CntW'(QDepth - 2))
    else $error("input stalled without a full queue");

endmodule
`default_nettype wire
